/* design/controller_to_gamepad_mapper_top_macros.svh */
// Assertion macros shared by the controller-to-gamepad mapper RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONTROLLER_TO_GAMEPAD_MAPPER_TOP_MACROS_SVH
`define CONTROLLER_TO_GAMEPAD_MAPPER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define C2GM_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define C2GM_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* design/c2gm_pkg.sv */
// Package for the controller-to-gamepad mapper: widths, register codes,
// gamepad button bits and the structs passed between the modules.
package c2gm_pkg;

	// Width of the internal time base; time_ms is cast to this width, so all 32 bits of time_ms are used.
	localparam int TIME_BITS = 32;

	// Configuration port geometry.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PRESS_LEVEL   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_LEVEL = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TIME     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_PULSE     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHORD_LEVEL   = 3'd4;

	// Register values after reset.
	localparam logic [7:0]  PRESS_LEVEL_RST   = 8'd140;
	localparam logic [7:0]  RELEASE_LEVEL_RST = 8'd115;
	localparam logic [15:0] HOLD_TIME_RST     = 16'd400;
	localparam logic [15:0] TAP_PULSE_RST     = 16'd100;
	localparam logic [14:0] CHORD_LEVEL_RST   = 15'd18022;

	// Gamepad button word bit positions.
	localparam int BTN_DUP       = 0;
	localparam int BTN_DDOWN     = 1;
	localparam int BTN_DLEFT     = 2;
	localparam int BTN_DRIGHT    = 3;
	localparam int BTN_START     = 4;
	localparam int BTN_BACK      = 5;
	localparam int BTN_LTHUMB    = 6;
	localparam int BTN_RTHUMB    = 7;
	localparam int BTN_LSHOULDER = 8;
	localparam int BTN_RSHOULDER = 9;
	localparam int BTN_A         = 12;
	localparam int BTN_B         = 13;
	localparam int BTN_X         = 14;
	localparam int BTN_Y         = 15;

	// Raw controller button bit positions.
	localparam int RAW_A      = 0;
	localparam int RAW_B      = 1;
	localparam int RAW_X      = 2;
	localparam int RAW_Y      = 3;
	localparam int RAW_LCLICK = 4;
	localparam int RAW_RCLICK = 5;
	localparam int RAW_MENU   = 6;

	// Analog latch bit positions.
	localparam int LAT_RT = 0;
	localparam int LAT_LT = 1;
	localparam int LAT_LG = 2;
	localparam int LAT_RG = 3;

	typedef struct packed {
		logic [7:0]  press_level;
		logic [7:0]  release_level;
		logic [15:0] hold_time_ms;
		logic [15:0] tap_pulse_ms;
		logic [14:0] chord_stick_level;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        time_ms;
		logic               tracking_ok;
		logic [7:0]         right_trigger_level;
		logic [7:0]         left_trigger_level;
		logic [7:0]         left_grip_level;
		logic [7:0]         right_grip_level;
		logic signed [15:0] left_stick_x;
		logic signed [15:0] left_stick_y;
		logic signed [15:0] right_stick_x;
		logic signed [15:0] right_stick_y;
		logic [6:0]         raw_buttons;
	} item_t;

	typedef struct packed {
		logic               report_active;
		logic [15:0]        button_mask;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic signed [15:0] turn_x;
		logic signed [15:0] turn_y;
		logic [7:0]         left_trigger_out;
		logic [7:0]         right_trigger_out;
		logic               recenter_request;
	} result_t;

	typedef struct packed {
		logic [3:0]           analog_latches;
		logic                 y_was_down;
		logic                 y_chord_used;
		logic [TIME_BITS-1:0] y_press_time;
		logic [TIME_BITS-1:0] y_pulse_until;
		logic                 recenter_latched;
	} state_t;

endpackage

/* design/c2gm_if.sv */
// Valid/ready channel interfaces for the mapper: controller frames in,
// gamepad reports out. Field widths follow the mapper package types.
interface c2gm_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        time_ms;
	logic               tracking_ok;
	logic [7:0]         right_trigger_level;
	logic [7:0]         left_trigger_level;
	logic [7:0]         left_grip_level;
	logic [7:0]         right_grip_level;
	logic signed [15:0] left_stick_x;
	logic signed [15:0] left_stick_y;
	logic signed [15:0] right_stick_x;
	logic signed [15:0] right_stick_y;
	logic [6:0]         raw_buttons;

	modport source (
		output valid, time_ms, tracking_ok, right_trigger_level, left_trigger_level,
		output left_grip_level, right_grip_level, left_stick_x, left_stick_y,
		output right_stick_x, right_stick_y, raw_buttons,
		input  ready
	);
	modport sink (
		input  valid, time_ms, tracking_ok, right_trigger_level, left_trigger_level,
		input  left_grip_level, right_grip_level, left_stick_x, left_stick_y,
		input  right_stick_x, right_stick_y, raw_buttons,
		output ready
	);
endinterface

interface c2gm_out_if;
	logic               valid;
	logic               ready;
	logic               report_active;
	logic [15:0]        button_mask;
	logic signed [15:0] move_x;
	logic signed [15:0] move_y;
	logic signed [15:0] turn_x;
	logic signed [15:0] turn_y;
	logic [7:0]         left_trigger_out;
	logic [7:0]         right_trigger_out;
	logic               recenter_request;

	modport source (
		output valid, report_active, button_mask, move_x, move_y, turn_x, turn_y,
		output left_trigger_out, right_trigger_out, recenter_request,
		input  ready
	);
	modport sink (
		input  valid, report_active, button_mask, move_x, move_y, turn_x, turn_y,
		input  left_trigger_out, right_trigger_out, recenter_request,
		output ready
	);
endinterface

/* design/c2gm_frame_logic.sv */
// Combinational frame logic of the mapper: from one controller frame and the
// current mapper state, builds the gamepad report and the next state.
// Depends on c2gm_pkg.
module c2gm_frame_logic (
	input  c2gm_pkg::cfg_t    cfg,
	input  c2gm_pkg::state_t  state,
	input  c2gm_pkg::item_t   item,
	output c2gm_pkg::state_t  state_next,
	output c2gm_pkg::result_t result
);

	// Hysteresis: a held latch needs a level strictly above release, an idle
	// latch turns on at or above press.
	function automatic logic latch_next(input logic was, input logic [7:0] level,
			input logic [7:0] press, input logic [7:0] rel);
		return was ? (level > rel) : (level >= press);
	endfunction

	// Clamp the one code outside the symmetric range.
	function automatic logic signed [15:0] sat_axis(input logic signed [15:0] v);
		return (v == 16'sh8000) ? 16'sh8001 : v;
	endfunction

	// Axis magnitude; the most negative code gives 32768 as unsigned.
	function automatic logic [15:0] axis_mag(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	logic [c2gm_pkg::TIME_BITS-1:0] now;
	logic [c2gm_pkg::TIME_BITS-1:0] hold_ext;
	logic [c2gm_pkg::TIME_BITS-1:0] press_eff;
	logic [c2gm_pkg::TIME_BITS-1:0] held;
	logic [c2gm_pkg::TIME_BITS-1:0] since_release;
	logic [c2gm_pkg::TIME_BITS-1:0] pulse_end;
	logic [c2gm_pkg::TIME_BITS-1:0] pulse_until_next;
	logic [c2gm_pkg::TIME_BITS:0]   pulse_sum;
	logic [3:0]  lat;
	logic        y, lc, rc, y_rise;
	logic [15:0] ax, ay, amax;
	logic        hold_reached, chord, chord_used_next, echo, tap, pulse;
	logic [3:0]  dir;
	logic        recenter, suppress;
	logic [15:0] btn;

	assign now      = c2gm_pkg::TIME_BITS'(item.time_ms);
	assign hold_ext = c2gm_pkg::TIME_BITS'(cfg.hold_time_ms);

	// Analog latches for the two triggers and two grips.
	assign lat[c2gm_pkg::LAT_RT] = latch_next(state.analog_latches[c2gm_pkg::LAT_RT],
		item.right_trigger_level, cfg.press_level, cfg.release_level);
	assign lat[c2gm_pkg::LAT_LT] = latch_next(state.analog_latches[c2gm_pkg::LAT_LT],
		item.left_trigger_level, cfg.press_level, cfg.release_level);
	assign lat[c2gm_pkg::LAT_LG] = latch_next(state.analog_latches[c2gm_pkg::LAT_LG],
		item.left_grip_level, cfg.press_level, cfg.release_level);
	assign lat[c2gm_pkg::LAT_RG] = latch_next(state.analog_latches[c2gm_pkg::LAT_RG],
		item.right_grip_level, cfg.press_level, cfg.release_level);

	assign y      = item.raw_buttons[c2gm_pkg::RAW_Y];
	assign lc     = item.raw_buttons[c2gm_pkg::RAW_LCLICK];
	assign rc     = item.raw_buttons[c2gm_pkg::RAW_RCLICK];
	assign y_rise = y && !state.y_was_down;

	// Y hold timer; a fresh press restarts it at the current time.
	assign press_eff    = y_rise ? now : state.y_press_time;
	assign held         = (y && now >= press_eff) ? (now - press_eff) : '0;
	assign hold_reached = y && (held >= hold_ext);

	// Chord: Y held and the left stick pushed far enough.
	assign ax   = axis_mag(item.left_stick_x);
	assign ay   = axis_mag(item.left_stick_y);
	assign amax = (ax > ay) ? ax : ay;
	assign chord = hold_reached && (amax >= {1'b0, cfg.chord_stick_level});

	always_comb begin
		dir = '0;
		if (chord) begin
			if (ay >= ax) begin
				if (!item.left_stick_y[15]) dir[c2gm_pkg::BTN_DUP] = 1'b1;
				else dir[c2gm_pkg::BTN_DDOWN] = 1'b1;
			end else begin
				if (!item.left_stick_x[15]) dir[c2gm_pkg::BTN_DRIGHT] = 1'b1;
				else dir[c2gm_pkg::BTN_DLEFT] = 1'b1;
			end
		end
	end

	assign chord_used_next = chord || (!y_rise && state.y_chord_used);
	assign echo            = hold_reached && !chord_used_next;

	// Tap: Y released before the hold time without a chord starts a pulse.
	assign since_release = now - state.y_press_time;
	assign tap = !y && state.y_was_down && !state.y_chord_used &&
		(now >= state.y_press_time) && (since_release < hold_ext);
	assign pulse_sum = {1'b0, now} + (c2gm_pkg::TIME_BITS + 1)'(cfg.tap_pulse_ms);
	assign pulse_end = pulse_sum[c2gm_pkg::TIME_BITS] ? '1
		: pulse_sum[c2gm_pkg::TIME_BITS-1:0];

	always_comb begin
		if (y_rise) begin
			pulse_until_next = '0;
		end else if (tap) begin
			pulse_until_next = pulse_end;
		end else begin
			pulse_until_next = state.y_pulse_until;
		end
	end

	assign pulse = !y && (now < pulse_until_next);

	// Recenter on the first frame with both clicks; mask clicks until both go.
	assign recenter = lc && rc && !state.recenter_latched;
	assign suppress = state.recenter_latched || recenter;

	// Button word.
	always_comb begin
		btn = {12'd0, dir};
		btn[c2gm_pkg::BTN_A]         = item.raw_buttons[c2gm_pkg::RAW_A];
		btn[c2gm_pkg::BTN_B]         = item.raw_buttons[c2gm_pkg::RAW_B];
		btn[c2gm_pkg::BTN_X]         = item.raw_buttons[c2gm_pkg::RAW_X];
		btn[c2gm_pkg::BTN_Y]         = pulse;
		btn[c2gm_pkg::BTN_LSHOULDER] = lat[c2gm_pkg::LAT_LG];
		btn[c2gm_pkg::BTN_RSHOULDER] = lat[c2gm_pkg::LAT_RG];
		btn[c2gm_pkg::BTN_LTHUMB]    = lc && !suppress;
		btn[c2gm_pkg::BTN_RTHUMB]    = rc && !suppress;
		btn[c2gm_pkg::BTN_START]     = item.raw_buttons[c2gm_pkg::RAW_MENU];
		btn[c2gm_pkg::BTN_BACK]      = echo;
	end

	// Report and next state; tracking loss gives a zero report and clears state.
	always_comb begin
		result     = '0;
		state_next = '0;
		if (item.tracking_ok) begin
			result.report_active     = 1'b1;
			result.button_mask       = btn;
			result.move_x            = (|dir) ? 16'sd0 : sat_axis(item.left_stick_x);
			result.move_y            = (|dir) ? 16'sd0 : sat_axis(item.left_stick_y);
			result.turn_x            = sat_axis(item.right_stick_x);
			result.turn_y            = sat_axis(item.right_stick_y);
			result.left_trigger_out  = !lat[c2gm_pkg::LAT_LT] ? 8'd0
				: ((item.left_trigger_level > cfg.press_level)
					? item.left_trigger_level : cfg.press_level);
			result.right_trigger_out = !lat[c2gm_pkg::LAT_RT] ? 8'd0
				: ((item.right_trigger_level > cfg.press_level)
					? item.right_trigger_level : cfg.press_level);
			result.recenter_request  = recenter;

			state_next.analog_latches   = lat;
			state_next.y_was_down       = y;
			state_next.y_chord_used     = chord_used_next;
			state_next.y_press_time     = press_eff;
			state_next.y_pulse_until    = pulse_until_next;
			state_next.recenter_latched = suppress && (lc || rc);
		end
	end

endmodule

/* design/controller_to_gamepad_mapper_top.sv */
// Controller-to-gamepad mapper top level: input register, mapper state,
// configuration registers and report register. Depends on c2gm_pkg,
// c2gm_if, c2gm_frame_logic and the assertion macro header.
//
// Takes one controller frame per clock cycle while the report output is not
// stalled, and returns one gamepad report per frame, in order. A frame is held
// in an input register, mapped by the combinational frame logic, which reads
// and updates the hysteresis, Y timer and recenter state, and lands in the
// report register when that register is empty or being drained. The input
// stays ready while a report waits to be taken, as long as the input register
// is free. Configuration writes take effect at once and belong to times when
// no frame is in flight.
`include "controller_to_gamepad_mapper_top_macros.svh"

module controller_to_gamepad_mapper_top (
	input  logic                                clk,
	input  logic                                arst_n,
	c2gm_in_if.sink                             frame_in,
	c2gm_out_if.source                          report_out,
	input  logic                                cfg_we,
	input  logic [c2gm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [c2gm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

	c2gm_pkg::cfg_t    cfg_q;
	c2gm_pkg::state_t  state_q;
	c2gm_pkg::state_t  state_next;
	c2gm_pkg::item_t   item_in;
	c2gm_pkg::item_t   item_s1;
	c2gm_pkg::result_t result_next;
	c2gm_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              accept_in;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_level       <= c2gm_pkg::PRESS_LEVEL_RST;
			cfg_q.release_level     <= c2gm_pkg::RELEASE_LEVEL_RST;
			cfg_q.hold_time_ms      <= c2gm_pkg::HOLD_TIME_RST;
			cfg_q.tap_pulse_ms      <= c2gm_pkg::TAP_PULSE_RST;
			cfg_q.chord_stick_level <= c2gm_pkg::CHORD_LEVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				c2gm_pkg::CFG_PRESS_LEVEL:   cfg_q.press_level <= cfg_wdata[7:0];
				c2gm_pkg::CFG_RELEASE_LEVEL: cfg_q.release_level <= cfg_wdata[7:0];
				c2gm_pkg::CFG_HOLD_TIME:     cfg_q.hold_time_ms <= cfg_wdata;
				c2gm_pkg::CFG_TAP_PULSE:     cfg_q.tap_pulse_ms <= cfg_wdata;
				c2gm_pkg::CFG_CHORD_LEVEL:   cfg_q.chord_stick_level <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// Handshake: the frame stage moves on whenever the report register is
	// empty or being drained.
	assign advance        = !valid_s2 || report_out.ready;
	assign frame_in.ready = !valid_s1 || advance;
	assign accept_in      = frame_in.valid && frame_in.ready;

	always_comb begin
		item_in.time_ms             = frame_in.time_ms;
		item_in.tracking_ok         = frame_in.tracking_ok;
		item_in.right_trigger_level = frame_in.right_trigger_level;
		item_in.left_trigger_level  = frame_in.left_trigger_level;
		item_in.left_grip_level     = frame_in.left_grip_level;
		item_in.right_grip_level    = frame_in.right_grip_level;
		item_in.left_stick_x        = frame_in.left_stick_x;
		item_in.left_stick_y        = frame_in.left_stick_y;
		item_in.right_stick_x       = frame_in.right_stick_x;
		item_in.right_stick_y       = frame_in.right_stick_y;
		item_in.raw_buttons         = frame_in.raw_buttons;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1 <= item_in;
		end
	end

	c2gm_frame_logic u_frame_logic (
		.cfg        (cfg_q),
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (result_next)
	);

	// Mapper state advances once per frame, when it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	// Report register.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result_next;
		end
	end

	assign report_out.valid             = valid_s2;
	assign report_out.report_active     = result_s2.report_active;
	assign report_out.button_mask       = result_s2.button_mask;
	assign report_out.move_x            = result_s2.move_x;
	assign report_out.move_y            = result_s2.move_y;
	assign report_out.turn_x            = result_s2.turn_x;
	assign report_out.turn_y            = result_s2.turn_y;
	assign report_out.left_trigger_out  = result_s2.left_trigger_out;
	assign report_out.right_trigger_out = result_s2.right_trigger_out;
	assign report_out.recenter_request  = result_s2.recenter_request;

	// At most one D-pad direction is reported.
	`C2GM_ASSERT_IMPLIES(a_dpad_onehot, valid_s2, $onehot0(result_s2.button_mask[3:0]), "more than one D-pad direction")
	// A D-pad chord zeroes movement and excludes BACK.
	`C2GM_ASSERT_IMPLIES(a_chord_no_move, valid_s2 && (|result_s2.button_mask[3:0]), result_s2.move_x == 16'sd0 && result_s2.move_y == 16'sd0 && !result_s2.button_mask[c2gm_pkg::BTN_BACK], "chord with movement or BACK")
	// A neutral report carries no buttons or recenter.
	`C2GM_ASSERT_IMPLIES(a_neutral_report, valid_s2 && !result_s2.report_active, result_s2.button_mask == 16'd0 && !result_s2.recenter_request, "neutral report not zero")
	// The input only stalls when both stages hold a frame.
	`C2GM_ASSERT_IMPLIES(a_stall_full, !frame_in.ready, valid_s1 && valid_s2, "input stalled with a free stage")
	// Mapper state does not move while the report register is stalled.
	`C2GM_ASSERT_CLK(a_state_hold, valid_s2 && !report_out.ready |=> $stable(state_q), "state changed during stall")

endmodule
